@@ rtl/sda_pkg.sv @@
// ----------------------------------------------------------------------------
// sda_pkg: shared types and constants for the spherical distance/azimuth block
// fixed-point formats, cordic arctangent table and the unit request and response structs
// ----------------------------------------------------------------------------
package sda_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STEPS    = 24;
  localparam int STEP_W          = $clog2(CORDIC_STEPS);
  localparam int OUT_SHIFT       = 32 - ANGLE_FRAC_BITS;

  localparam int LAT_W  = 24;
  localparam int LON_W  = 25;
  localparam int DIST_W = 24;
  localparam int AZI_W  = 25;
  localparam int TRIG_W = 34;   // multiplier operand, q30 plus headroom
  localparam int ATAN_N = 12;

  // angles inside the block: signed degrees times 2^32
  localparam logic signed [63:0] DEG90     = 64'sd90 <<< 32;
  localparam logic signed [63:0] DEG180    = 64'sd180 <<< 32;
  localparam logic signed [63:0] DEG360    = 64'sd360 <<< 32;
  localparam logic signed [63:0] ONE_Q30   = 64'sd1 <<< 30;
  localparam logic signed [63:0] ONE_SQ    = 64'sd1 <<< 60;
  localparam logic signed [63:0] INV_GAIN  = 64'sd652032874;

  localparam logic signed [LAT_W-1:0] LAT_LIM = LAT_W'(90 << ANGLE_FRAC_BITS);
  localparam logic signed [63:0] FULL_OUT = 64'sd360 <<< ANGLE_FRAC_BITS;
  localparam logic [DIST_W-1:0] DIST_MAX  = DIST_W'(180 << ANGLE_FRAC_BITS);
  localparam logic [AZI_W-1:0]  AZI_MAX   = AZI_W'(360 << ANGLE_FRAC_BITS);
  localparam logic [AZI_W-1:0]  BAZ_SAME  = AZI_W'(180 << ANGLE_FRAC_BITS);

  // value in nano-degrees to degrees times 2^32
  function automatic logic signed [63:0] nano_to_q32(logic [63:0] nd);
    logic [63:0] whole;
    logic [63:0] frac;
    whole = nd / 64'd1000000000;
    frac  = ((nd % 64'd1000000000) << 32) / 64'd1000000000;
    return $signed((whole << 32) + frac);
  endfunction

  localparam logic signed [63:0] COEF_SIN2  = nano_to_q32(64'd192436000);
  localparam logic signed [63:0] COEF_SIN4  = nano_to_q32(64'd323000);
  localparam logic signed [63:0] RADIAN_Q32 = nano_to_q32(64'd57295779513);

  localparam logic signed [63:0] ATAN_TAB [ATAN_N] = '{
    nano_to_q32(64'd45000000000), nano_to_q32(64'd26565051177),
    nano_to_q32(64'd14036243468), nano_to_q32(64'd7125016349),
    nano_to_q32(64'd3576334375),  nano_to_q32(64'd1789910608),
    nano_to_q32(64'd895173710),   nano_to_q32(64'd447614171),
    nano_to_q32(64'd223810500),   nano_to_q32(64'd111905677),
    nano_to_q32(64'd55952892),    nano_to_q32(64'd27976453)
  };

  // atan(2^-i) in degrees; beyond the table the small-angle form
  function automatic logic signed [63:0] atan_step(logic [STEP_W-1:0] i);
    if (i < STEP_W'(ATAN_N)) begin
      return ATAN_TAB[i[3:0]];
    end
    return RADIAN_Q32 >>> i;
  endfunction

  // round half up from 2^-32 degree to the port scale
  function automatic logic signed [63:0] to_out(logic signed [63:0] q);
    return (q + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
  endfunction

  typedef struct packed {
    logic               start;
    logic               vec;     // 1: vectoring (atan2), 0: rotation (sin/cos)
    logic signed [63:0] angle;
    logic signed [63:0] x;
    logic signed [63:0] y;
  } cordic_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } cordic_rsp_t;

endpackage

@@ rtl/sda_if.sv @@
// ----------------------------------------------------------------------------
// sda_if: request and result channels
// valid/ready handshake with the point pair and the distance/azimuth result
// ----------------------------------------------------------------------------
interface sda_req_if;
  logic                                valid;
  logic                                ready;
  logic signed [sda_pkg::LAT_W-1:0]    lat_first;
  logic signed [sda_pkg::LON_W-1:0]    lon_first;
  logic signed [sda_pkg::LAT_W-1:0]    lat_second;
  logic signed [sda_pkg::LON_W-1:0]    lon_second;
  logic                                reuse_second;
  modport source (output valid, lat_first, lon_first, lat_second, lon_second,
                  reuse_second, input ready);
  modport sink (input valid, lat_first, lon_first, lat_second, lon_second,
                reuse_second, output ready);
endinterface

interface sda_res_if;
  logic                          valid;
  logic                          ready;
  logic [sda_pkg::DIST_W-1:0]    distance;
  logic [sda_pkg::AZI_W-1:0]     azimuth;
  logic [sda_pkg::AZI_W-1:0]     back_azimuth;
  modport source (output valid, distance, azimuth, back_azimuth, input ready);
  modport sink (input valid, distance, azimuth, back_azimuth, output ready);
endinterface

@@ rtl/sda_cordic.sv @@
// ----------------------------------------------------------------------------
// sda_cordic: shared iterative cordic unit
// rotation mode gives cos/sin of a degree angle, vectoring mode gives atan2
// ----------------------------------------------------------------------------
module sda_cordic (
  input  logic                 clk,
  input  logic                 rst,
  input  sda_pkg::cordic_req_t req,
  output sda_pkg::cordic_rsp_t rsp
);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_WRAP = 4'b0010,
    C_RUN  = 4'b0100,
    C_FIN  = 4'b1000
  } cst_t;

  cst_t                         state;
  logic                         vec;
  logic                         neg;
  logic [sda_pkg::STEP_W-1:0]   idx;
  logic signed [63:0]           x;
  logic signed [63:0]           y;
  logic signed [63:0]           z;
  logic signed [63:0]           dx;
  logic signed [63:0]           dy;
  logic signed [63:0]           at;
  logic                         dir;

  assign dx  = y >>> idx;
  assign dy  = x >>> idx;
  assign at  = sda_pkg::atan_step(idx);
  // rotation drives z to zero, vectoring drives y to zero
  assign dir = vec ? y[63] : !z[63];

  assign rsp.busy = (state != C_IDLE);
  assign rsp.done = (state == C_FIN);
  assign rsp.x    = neg ? -x : x;
  assign rsp.y    = neg ? -y : y;
  assign rsp.z    = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (req.start) begin
            vec <= req.vec;
            neg <= 1'b0;
            idx <= '0;
            if (req.vec) begin
              if (req.x == 64'sd0 && req.y == 64'sd0) begin
                x     <= '0;
                y     <= '0;
                z     <= '0;
                state <= C_FIN;
              end else if (req.x < 64'sd0) begin
                // pre-rotate into the right half plane
                if (req.y >= 64'sd0) begin
                  x <= req.y;
                  y <= -req.x;
                  z <= sda_pkg::DEG90;
                end else begin
                  x <= -req.y;
                  y <= req.x;
                  z <= -sda_pkg::DEG90;
                end
                state <= C_RUN;
              end else begin
                x     <= req.x;
                y     <= req.y;
                z     <= '0;
                state <= C_RUN;
              end
            end else begin
              x     <= sda_pkg::INV_GAIN;
              y     <= '0;
              z     <= req.angle;
              state <= C_WRAP;
            end
          end
        end
        C_WRAP: begin
          // one step of range reduction per cycle, then fold to +-90
          if (z >= sda_pkg::DEG180) begin
            z <= z - sda_pkg::DEG360;
          end else if (z < -sda_pkg::DEG180) begin
            z <= z + sda_pkg::DEG360;
          end else if (z > sda_pkg::DEG90) begin
            z     <= z - sda_pkg::DEG180;
            neg   <= 1'b1;
            state <= C_RUN;
          end else if (z < -sda_pkg::DEG90) begin
            z     <= z + sda_pkg::DEG180;
            neg   <= 1'b1;
            state <= C_RUN;
          end else begin
            state <= C_RUN;
          end
        end
        C_RUN: begin
          if (dir) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - at;
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + at;
          end
          idx <= idx + 1'b1;
          if (idx == sda_pkg::STEP_W'(sda_pkg::CORDIC_STEPS - 1)) begin
            state <= C_FIN;
          end
        end
        C_FIN: begin
          state <= C_IDLE;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/sda_isqrt.sv @@
// ----------------------------------------------------------------------------
// sda_isqrt: bit-pair integer square root
// one result bit per cycle, a 32-bit root for a 64-bit radicand
// ----------------------------------------------------------------------------
module sda_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [63:0] rem;
  logic [63:0] r;
  logic [63:0] bit_r;
  logic [63:0] trial;

  assign trial = r + bit_r;
  assign root  = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        rem   <= radicand;
        r     <= '0;
        bit_r <= 64'd1 << 62;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          r   <= (r >> 1) + bit_r;
        end else begin
          r   <= r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r == 64'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/spherical_distance_azimuth.sv @@
// ----------------------------------------------------------------------------
// spherical_distance_azimuth: great-circle distance, azimuth and back azimuth
// between two geographic points, geocentric latitude correction, cached
// sine/cosine of point 2
// ----------------------------------------------------------------------------
// sequence: reuse_second skips the point-2 pass; each cordic run is 24
//   iterations, after range reduction in rotation mode, and the cordic runs
//   and the square root all run strictly one after another
// requests: one at a time, ready only while the sequencer is idle
// identical points: with reuse straight to the result, else after the cache update
// reset: synchronous, clears the sequencer, result valid and the cached
//   point-2 sine/cosine to zero
module spherical_distance_azimuth (
  input  logic      clk,
  input  logic      rst,
  sda_req_if.sink   req,
  sda_res_if.source res
);

  // sequencer states: geocentric pass per point, dlon, products, sqrt, atan2s
  typedef enum logic [26:0] {
    S_IDLE  = 27'd1 << 0,
    S_COLAT = 27'd1 << 1,
    S_SC2   = 27'd1 << 2,
    S_SC4   = 27'd1 << 3,
    S_CORR2 = 27'd1 << 4,
    S_CORR4 = 27'd1 << 5,
    S_GEO   = 27'd1 << 6,
    S_SCG   = 27'd1 << 7,
    S_SCD   = 27'd1 << 8,
    S_M1    = 27'd1 << 9,
    S_M2    = 27'd1 << 10,
    S_M3    = 27'd1 << 11,
    S_M4    = 27'd1 << 12,
    S_M5    = 27'd1 << 13,
    S_M6    = 27'd1 << 14,
    S_M7    = 27'd1 << 15,
    S_M8    = 27'd1 << 16,
    S_M9    = 27'd1 << 17,
    S_M10   = 27'd1 << 18,
    S_M11   = 27'd1 << 19,
    S_SQRT  = 27'd1 << 20,
    S_ATD   = 27'd1 << 21,
    S_ATA   = 27'd1 << 22,
    S_ATB   = 27'd1 << 23,
    S_FIN   = 27'd1 << 24,
    S_SPR1  = 27'd1 << 25,
    S_SPR2  = 27'd1 << 26
  } state_t;

  localparam int TW = sda_pkg::TRIG_W;

  state_t state;

  // latched request
  logic signed [sda_pkg::LAT_W-1:0] lat1;
  logic signed [sda_pkg::LAT_W-1:0] lat2;
  logic signed [sda_pkg::LON_W-1:0] lon1;
  logic signed [sda_pkg::LON_W-1:0] lon2;
  logic                             same;
  logic                             pt_first;

  // geocentric correction temporaries
  logic signed [63:0] colat;
  logic signed [TW-1:0] s2c;
  logic signed [TW-1:0] s4c;
  logic signed [63:0] corr;

  // trig values, q30
  logic signed [TW-1:0] c1;
  logic signed [TW-1:0] s1;
  logic signed [TW-1:0] cd;
  logic signed [TW-1:0] sd;
  logic signed [31:0]   cache_cos;
  logic signed [31:0]   cache_sin;

  // product terms
  logic signed [63:0] ta;
  logic signed [31:0] cdel;
  logic signed [TW-1:0] m4;
  logic signed [TW-1:0] m5;
  logic signed [63:0] yazi;
  logic signed [63:0] xazi;
  logic signed [63:0] ybaz;
  logic signed [63:0] xbaz;

  // result holding and output registers
  logic [sda_pkg::DIST_W-1:0] dist_r;
  logic [sda_pkg::AZI_W-1:0]  azi_r;
  logic [sda_pkg::AZI_W-1:0]  baz_r;
  logic                       out_valid;
  logic [sda_pkg::DIST_W-1:0] out_dist;
  logic [sda_pkg::AZI_W-1:0]  out_azi;
  logic [sda_pkg::AZI_W-1:0]  out_baz;

  // shared multiplier
  logic signed [TW-1:0]     mul_a;
  logic signed [TW-1:0]     mul_b;
  logic signed [2*TW-1:0]   mul_full;
  logic signed [63:0]       prod;
  logic signed [63:0]       p;

  // shared units
  sda_pkg::cordic_req_t creq;
  sda_pkg::cordic_rsp_t crsp;
  logic                 sq_start;
  logic [63:0]          sq_in;
  logic                 sq_done;
  logic [31:0]          sq_root;

  // combinational helpers
  logic signed [sda_pkg::LAT_W-1:0] lat_sel;
  logic signed [sda_pkg::LAT_W-1:0] lat_sat;
  logic signed [63:0]               latq;
  logic signed [63:0]               colat_w;
  logic signed [63:0]               dlon;
  logic signed [63:0]               cdel_w;
  logic signed [63:0]               dist_q;
  logic signed [63:0]               angle_out;
  logic signed [63:0]               wrap_out;

  sda_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .rsp (crsp)
  );

  sda_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_in),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign req.ready        = (state == S_IDLE);
  assign res.valid        = out_valid;
  assign res.distance     = out_dist;
  assign res.azimuth      = out_azi;
  assign res.back_azimuth = out_baz;

  // latitude saturation and scaling to 2^-32 degree
  assign lat_sel = pt_first ? lat1 : lat2;
  always_comb begin
    lat_sat = lat_sel;
    if (lat_sel > sda_pkg::LAT_LIM) begin
      lat_sat = sda_pkg::LAT_LIM;
    end else if (lat_sel < -sda_pkg::LAT_LIM) begin
      lat_sat = -sda_pkg::LAT_LIM;
    end
  end
  assign latq    = 64'(lat_sat) <<< sda_pkg::OUT_SHIFT;
  assign colat_w = sda_pkg::DEG90 - latq;
  assign dlon    = (64'(lon2) - 64'(lon1)) <<< sda_pkg::OUT_SHIFT;

  // cosine of the distance, clamped to [-1,1]
  always_comb begin
    cdel_w = ta + p;
    if (cdel_w > sda_pkg::ONE_Q30) begin
      cdel_w = sda_pkg::ONE_Q30;
    end else if (cdel_w < -sda_pkg::ONE_Q30) begin
      cdel_w = -sda_pkg::ONE_Q30;
    end
  end

  // distance clamp to [0,180] before rounding
  always_comb begin
    dist_q = crsp.z;
    if (crsp.z < 64'sd0) begin
      dist_q = '0;
    end else if (crsp.z > sda_pkg::DEG180) begin
      dist_q = sda_pkg::DEG180;
    end
  end

  // azimuth rounding, negative results moved up by a full turn
  assign angle_out = sda_pkg::to_out(crsp.z);
  assign wrap_out  = (angle_out < 64'sd0) ? angle_out + sda_pkg::FULL_OUT : angle_out;

  // multiplier operand selection per product step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_CORR2: begin mul_a = TW'(sda_pkg::COEF_SIN2); mul_b = s2c; end
      S_CORR4: begin mul_a = TW'(sda_pkg::COEF_SIN4); mul_b = s4c; end
      S_M1:    begin mul_a = s1;     mul_b = TW'(cache_sin); end
      S_M2:    begin mul_a = c1;     mul_b = TW'(cache_cos); end
      S_M3:    begin mul_a = TW'(p); mul_b = cd; end
      S_M4:    begin mul_a = sd;     mul_b = TW'(cache_cos); end
      S_M5:    begin mul_a = c1;     mul_b = TW'(cache_sin); end
      S_M6:    begin mul_a = s1;     mul_b = TW'(cache_cos); end
      S_M7:    begin mul_a = TW'(p); mul_b = cd; end
      S_M8:    begin mul_a = m4;     mul_b = cd; end
      S_M9:    begin mul_a = sd;     mul_b = c1; end
      S_M10:   begin mul_a = TW'(cdel); mul_b = TW'(cdel); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_full = mul_a * mul_b;
  assign p        = prod >>> 30;

  always_ff @(posedge clk) begin
    prod <= mul_full[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      creq.start <= 1'b0;
      sq_start   <= 1'b0;
      cache_cos  <= '0;
      cache_sin  <= '0;
    end else begin
      creq.start <= 1'b0;
      sq_start   <= 1'b0;
      // a result taken while a new one is handed over stays valid
      if (res.valid && res.ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            lat1 <= req.lat_first;
            lon1 <= req.lon_first;
            lat2 <= req.lat_second;
            lon2 <= req.lon_second;
            same <= (req.lat_first == req.lat_second) &&
                    (req.lon_first == req.lon_second);
            if (!req.reuse_second) begin
              pt_first <= 1'b0;
              state    <= S_COLAT;
            end else if ((req.lat_first == req.lat_second) &&
                         (req.lon_first == req.lon_second)) begin
              dist_r <= '0;
              azi_r  <= '0;
              baz_r  <= sda_pkg::BAZ_SAME;
              state  <= S_FIN;
            end else begin
              pt_first <= 1'b1;
              state    <= S_COLAT;
            end
          end
        end
        S_COLAT: begin
          colat      <= colat_w;
          creq.vec   <= 1'b0;
          creq.angle <= colat_w <<< 1;
          creq.start <= 1'b1;
          state      <= S_SC2;
        end
        S_SC2: begin
          if (crsp.done) begin
            s2c        <= TW'(crsp.y);
            creq.angle <= colat <<< 2;
            creq.start <= 1'b1;
            state      <= S_SC4;
          end
        end
        S_SC4: begin
          if (crsp.done) begin
            s4c   <= TW'(crsp.y);
            state <= S_CORR2;
          end
        end
        S_CORR2: begin
          state <= S_CORR4;
        end
        S_CORR4: begin
          corr  <= p;
          state <= S_GEO;
        end
        S_GEO: begin
          // geocentric latitude = 90 - corrected colatitude
          creq.angle <= sda_pkg::DEG90 - (colat + corr + p);
          creq.start <= 1'b1;
          state      <= S_SCG;
        end
        S_SCG: begin
          if (crsp.done) begin
            if (!pt_first) begin
              cache_cos <= crsp.x[31:0];
              cache_sin <= crsp.y[31:0];
              if (same) begin
                dist_r <= '0;
                azi_r  <= '0;
                baz_r  <= sda_pkg::BAZ_SAME;
                state  <= S_FIN;
              end else begin
                pt_first <= 1'b1;
                state    <= S_COLAT;
              end
            end else begin
              c1         <= TW'(crsp.x);
              s1         <= TW'(crsp.y);
              creq.angle <= dlon;
              creq.start <= 1'b1;
              state      <= S_SCD;
            end
          end
        end
        S_SCD: begin
          if (crsp.done) begin
            cd    <= TW'(crsp.x);
            sd    <= TW'(crsp.y);
            state <= S_M1;
          end
        end
        S_M1: state <= S_M2;
        S_M2: begin
          ta    <= p;
          state <= S_M3;
        end
        S_M3: state <= S_M4;
        S_M4: begin
          cdel  <= cdel_w[31:0];
          state <= S_M5;
        end
        S_M5: begin
          yazi  <= p;
          state <= S_M6;
        end
        S_M6: begin
          m4    <= TW'(p);
          state <= S_M7;
        end
        S_M7: begin
          m5    <= TW'(p);
          state <= S_M8;
        end
        S_M8: begin
          xazi  <= 64'(m4) - p;
          state <= S_M9;
        end
        S_M9: begin
          xbaz  <= 64'(m5) - p;
          state <= S_M10;
        end
        S_M10: begin
          ybaz  <= -p;
          state <= S_M11;
        end
        S_M11: begin
          // sin of the distance from 1 - cos^2
          sq_in    <= $unsigned(sda_pkg::ONE_SQ - prod);
          sq_start <= 1'b1;
          state    <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_done) begin
            creq.vec   <= 1'b1;
            creq.y     <= 64'(sq_root);
            creq.x     <= 64'(cdel);
            creq.start <= 1'b1;
            state      <= S_ATD;
          end
        end
        S_ATD: begin
          if (crsp.done) begin
            dist_r     <= sda_pkg::DIST_W'(sda_pkg::to_out(dist_q));
            creq.y     <= yazi;
            creq.x     <= xazi;
            creq.start <= 1'b1;
            state      <= S_ATA;
          end
        end
        S_ATA: begin
          if (crsp.done) begin
            azi_r      <= sda_pkg::AZI_W'(wrap_out);
            creq.y     <= ybaz;
            creq.x     <= xbaz;
            creq.start <= 1'b1;
            state      <= S_ATB;
          end
        end
        S_ATB: begin
          if (crsp.done) begin
            baz_r <= sda_pkg::AZI_W'(wrap_out);
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // hand over to the output register once it is free
          if (!out_valid || res.ready) begin
            out_valid <= 1'b1;
            out_dist  <= dist_r;
            out_azi   <= azi_r;
            out_baz   <= baz_r;
            state     <= S_IDLE;
          end
        end
        S_SPR1, S_SPR2: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // cordic is only started while it is idle
  a_cordic_free: assert property (@(posedge clk) disable iff (rst)
    creq.start |-> !crsp.busy)
    else $error("cordic started while busy");

  // an accepted request blocks the next one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second request accepted while working");

  // results stay in range
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.distance <= sda_pkg::DIST_MAX))
    else $error("distance out of range");

  a_azi_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.azimuth <= sda_pkg::AZI_MAX &&
                   res.back_azimuth <= sda_pkg::AZI_MAX))
    else $error("azimuth out of range");

endmodule
